// File: sv/isp_pkg.sv
// ----------------------------------------------------------------------------
// isp_pkg
// Shared constants, types and helpers of the inverse Park / SVPWM core.
// ----------------------------------------------------------------------------
package isp_pkg;

  // fixed point widths
  localparam int TW = 17;  // active vector time, unsigned
  localparam int SW = 18;  // sum of the two active times
  localparam int QW = 15;  // scaled time, 0..16384
  localparam int PhW = 15; // phase on-time, 0..16384

  localparam logic [QW-1:0] PeriodQ14 = 15'd16384;
  localparam logic [QW-1:0] HalfPeriodQ14 = 15'd8192;
  localparam logic signed [15:0] Sqrt3HalfQ14 = 16'sd14189;

  localparam int DefaultSineEntries = 1024;
  localparam logic [15:0] CompareTopReset = 16'd499;
  localparam logic [15:0] CompareGainReset = 16'd500;

  // register indexes
  localparam logic CfgCompareTop = 1'b0;
  localparam logic CfgCompareGain = 1'b1;

  // sector numbers
  localparam logic [2:0] SecNull = 3'd0;
  localparam logic [2:0] Sec1 = 3'd1;
  localparam logic [2:0] Sec2 = 3'd2;
  localparam logic [2:0] Sec3 = 3'd3;
  localparam logic [2:0] Sec4 = 3'd4;
  localparam logic [2:0] Sec5 = 3'd5;
  localparam logic [2:0] Sec6 = 3'd6;

  // projection sign codes
  localparam logic [2:0] CodeSec1 = 3'b101;
  localparam logic [2:0] CodeSec2 = 3'b100;
  localparam logic [2:0] CodeSec3 = 3'b110;
  localparam logic [2:0] CodeSec4 = 3'b010;
  localparam logic [2:0] CodeSec5 = 3'b011;
  localparam logic [2:0] CodeSec6 = 3'b001;

  // sideband carried alongside the divider
  typedef struct packed {
    logic [2:0]    sector;
    logic          over;
    logic [TW-1:0] t1;
    logic [TW-1:0] t2;
  } isp_side_t;

  // sin(pi/2 * x), x and result in Q30, 9th order polynomial
  function automatic longint unsigned quarter_sine(longint unsigned x);
    longint unsigned x2;
    longint unsigned p;
    x2 = (x * x) >> 30;
    p = 64'd172272;
    p = 64'd5026995 - ((x2 * p) >> 30);
    p = 64'd85569306 - ((x2 * p) >> 30);
    p = 64'd693598671 - ((x2 * p) >> 30);
    p = 64'd1686629713 - ((x2 * p) >> 30);
    return (x * p) >> 30;
  endfunction

endpackage

// File: sv/isp_if.sv
// ----------------------------------------------------------------------------
// isp channel interfaces
// Valid/ready channels for voltage commands and compare results.
// ----------------------------------------------------------------------------
interface isp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] volt_d;
  logic signed [15:0] volt_q;
  logic [15:0]        elec_angle;

  modport source (output valid, volt_d, volt_q, elec_angle, input ready);
  modport sink (input valid, volt_d, volt_q, elec_angle, output ready);
endinterface

interface isp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] cmp_phase_a;
  logic [15:0] cmp_phase_b;
  logic [15:0] cmp_phase_c;
  logic [2:0]  sector_num;

  modport source (output valid, cmp_phase_a, cmp_phase_b, cmp_phase_c, sector_num,
                  input ready);
  modport sink (input valid, cmp_phase_a, cmp_phase_b, cmp_phase_c, sector_num,
                output ready);
endinterface

// File: sv/isp_div.sv
// ----------------------------------------------------------------------------
// isp_div
// Pipelined restoring divider: t1 * 16384 / sum and t2 * 16384 / sum, one
// quotient bit per stage, numerators never above the sum.
// ----------------------------------------------------------------------------
module isp_div import isp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [SW-1:0] sum_i,
  input  isp_side_t     side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo1_o,
  output logic [QW-1:0] quo2_o,
  output isp_side_t     side_o
);

  localparam int Steps = QW;

  logic            vld_a [Steps];
  logic [SW-1:0]   sum_a [Steps];
  logic [SW-1:0]   rem1_a [Steps];
  logic [SW-1:0]   rem2_a [Steps];
  logic [QW-1:0]   quo1_a [Steps];
  logic [QW-1:0]   quo2_a [Steps];
  isp_side_t       side_a [Steps];

  logic            vld_q [Steps];
  logic [SW-1:0]   sum_q [Steps];
  logic [SW-1:0]   rem1_q [Steps];
  logic [SW-1:0]   rem2_q [Steps];
  logic [QW-1:0]   quo1_q [Steps];
  logic [QW-1:0]   quo2_q [Steps];
  isp_side_t       side_q [Steps];

  // stage inputs: first from the ports, later from the previous stage
  always_comb begin
    vld_a[0]  = valid_i;
    sum_a[0]  = sum_i;
    rem1_a[0] = SW'(side_i.t1);
    rem2_a[0] = SW'(side_i.t2);
    quo1_a[0] = '0;
    quo2_a[0] = '0;
    side_a[0] = side_i;
    for (int k = 1; k < Steps; k++) begin
      vld_a[k]  = vld_q[k-1];
      sum_a[k]  = sum_q[k-1];
      rem1_a[k] = rem1_q[k-1];
      rem2_a[k] = rem2_q[k-1];
      quo1_a[k] = quo1_q[k-1];
      quo2_a[k] = quo2_q[k-1];
      side_a[k] = side_q[k-1];
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [SW:0] sh1, sh2;
    logic        ge1, ge2;

    // one quotient bit per numerator
    always_comb begin
      sh1 = (k == 0) ? {1'b0, rem1_a[k]} : {rem1_a[k], 1'b0};
      sh2 = (k == 0) ? {1'b0, rem2_a[k]} : {rem2_a[k], 1'b0};
      ge1 = sh1 >= {1'b0, sum_a[k]};
      ge2 = sh2 >= {1'b0, sum_a[k]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_a[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sum_q[k]  <= sum_a[k];
        side_q[k] <= side_a[k];
        rem1_q[k] <= ge1 ? SW'(sh1 - {1'b0, sum_a[k]}) : SW'(sh1);
        rem2_q[k] <= ge2 ? SW'(sh2 - {1'b0, sum_a[k]}) : SW'(sh2);
        quo1_q[k] <= quo1_a[k] | (QW'(ge1) << (QW - 1 - k));
        quo2_q[k] <= quo2_a[k] | (QW'(ge2) << (QW - 1 - k));
      end
    end
  end

  assign valid_o = vld_q[Steps-1];
  assign quo1_o  = quo1_q[Steps-1];
  assign quo2_o  = quo2_q[Steps-1];
  assign side_o  = side_q[Steps-1];

endmodule

// File: sv/inverse_park_svpwm_core.sv
// ----------------------------------------------------------------------------
// inverse_park_svpwm_core
// Inverse Park rotation and space vector PWM with overmodulation scaling.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries volt_d, volt_q (Q2.14) and elec_angle (16 bits per turn).
//   out_ch returns the three center-aligned compare values and the sector
//   number (1..6, 0 for the null vector), one result per input transaction.
//   cfg_we_i / cfg_idx_i / cfg_wdata_i write compare_top (index 0) and
//   compare_gain (index 1); write them only while no transaction is in flight.
// Timing:
//   one transaction is taken every cycle while out_ch is not stalled with
//   data. The pipeline holds a sine ROM stage, two multiply/round pairs, a
//   sector stage, a 15-stage divider (one quotient bit per stage), a phase
//   time stage, a gain multiply and the output register.
// Reset and stall:
//   reset empties the pipeline and loads compare_top = 499, compare_gain =
//   500. The whole pipeline advances only when the output register is empty
//   or being taken, so in_ch.ready drops while out_ch is stalled with data.
// ----------------------------------------------------------------------------
module inverse_park_svpwm_core import isp_pkg::*; #(
  parameter int SINE_TABLE_ENTRIES = DefaultSineEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  isp_in_if.sink      in_ch,
  isp_out_if.source   out_ch,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int AW = $clog2(SINE_TABLE_ENTRIES);

  typedef logic signed [15:0] rom_t [SINE_TABLE_ENTRIES];

  // sine table in Q1.14, quarter wave polynomial mirrored over one turn
  function automatic rom_t build_rom();
    rom_t            r;
    longint unsigned pos;
    longint unsigned quad;
    longint unsigned x;
    longint unsigned s;
    for (int i = 0; i < SINE_TABLE_ENTRIES; i++) begin
      pos = 64'(4 * i);
      quad = pos / SINE_TABLE_ENTRIES;
      x = ((pos % SINE_TABLE_ENTRIES) << 30) / SINE_TABLE_ENTRIES;
      if (quad[0]) x = (64'd1 << 30) - x;
      s = (quarter_sine(x) + 64'd32768) >> 16;
      if (s > 64'd16384) s = 64'd16384;
      r[i] = quad[1] ? -16'(s) : 16'(s);
    end
    return r;
  endfunction

  localparam rom_t SineRom = build_rom();

  logic en;

  // configuration registers
  logic [15:0] top_q, gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q  <= CompareTopReset;
      gain_q <= CompareGainReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgCompareTop) top_q <= cfg_wdata_i;
      if (cfg_idx_i == CfgCompareGain) gain_q <= cfg_wdata_i;
    end
  end

  // stage 1: sine and cosine ROM read
  logic [15+AW:0] sprod, cprod;
  logic [15:0]    cang;
  logic [AW-1:0]  sidx, cidx;

  always_comb begin
    cang  = in_ch.elec_angle + 16'd16384;
    sprod = (16 + AW)'(32'(in_ch.elec_angle) * SINE_TABLE_ENTRIES);
    cprod = (16 + AW)'(32'(cang) * SINE_TABLE_ENTRIES);
    sidx  = sprod[15+AW:16];
    cidx  = cprod[15+AW:16];
  end

  logic               v1_q;
  logic signed [15:0] sn1_q, cs1_q, vd1_q, vq1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sn1_q <= SineRom[sidx];
      cs1_q <= SineRom[cidx];
      vd1_q <= in_ch.volt_d;
      vq1_q <= in_ch.volt_q;
    end
  end

  // stage 2: rotation products
  logic               v2_q;
  logic signed [31:0] pdc2_q, pqs2_q, pds2_q, pqc2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pdc2_q <= vd1_q * cs1_q;
      pqs2_q <= vq1_q * sn1_q;
      pds2_q <= vd1_q * sn1_q;
      pqc2_q <= vq1_q * cs1_q;
    end
  end

  // stage 3: alpha/beta rounding
  logic signed [32:0] asum, bsum;
  logic signed [32:0] arnd, brnd;
  logic               v3_q;
  logic signed [17:0] ua3_q, ub3_q;

  always_comb begin
    asum = 33'(pdc2_q) - 33'(pqs2_q) + 33'sd8192;
    bsum = 33'(pds2_q) + 33'(pqc2_q) + 33'sd8192;
    arnd = asum >>> 14;
    brnd = bsum >>> 14;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ua3_q <= arnd[17:0];
      ub3_q <= brnd[17:0];
    end
  end

  // stage 4: sqrt(3)/2 product
  logic               v4_q;
  logic signed [33:0] ma4_q;
  logic signed [17:0] ub4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ma4_q <= 34'(ua3_q) * 34'(Sqrt3HalfQ14);
      ub4_q <= ub3_q;
    end
  end

  // stage 5: three axis projections
  logic signed [34:0] hb, s2, s3, r2, r3;
  logic               v5_q;
  logic signed [17:0] u1_5_q, u2_5_q, u3_5_q;

  always_comb begin
    hb = 35'(ub4_q) <<< 13;
    s2 = -35'(ma4_q) - hb + 35'sd8192;
    s3 = 35'(ma4_q) - hb + 35'sd8192;
    r2 = s2 >>> 14;
    r3 = s3 >>> 14;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u1_5_q <= ub4_q;
      u2_5_q <= r2[17:0];
      u3_5_q <= r3[17:0];
    end
  end

  // stage 6: sector decode and active times
  logic [2:0]         code;
  logic [2:0]         sec;
  logic signed [17:0] t1s, t2s;
  logic [SW-1:0]      tsum;
  logic               v6_q;
  logic [SW-1:0]      sum6_q;
  isp_side_t          side6_q;

  always_comb begin
    code = {u1_5_q > 0, u2_5_q > 0, u3_5_q > 0};
    case (code)
      CodeSec1: begin sec = Sec1; t1s = u3_5_q;  t2s = u1_5_q;  end
      CodeSec2: begin sec = Sec2; t1s = -u3_5_q; t2s = -u2_5_q; end
      CodeSec3: begin sec = Sec3; t1s = u1_5_q;  t2s = u2_5_q;  end
      CodeSec4: begin sec = Sec4; t1s = -u1_5_q; t2s = -u3_5_q; end
      CodeSec5: begin sec = Sec5; t1s = u2_5_q;  t2s = u3_5_q;  end
      CodeSec6: begin sec = Sec6; t1s = -u2_5_q; t2s = -u1_5_q; end
      default:  begin sec = SecNull; t1s = '0;   t2s = '0;      end
    endcase
    tsum = SW'(t1s[TW-1:0]) + SW'(t2s[TW-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum6_q         <= tsum;
      side6_q.sector <= sec;
      side6_q.over   <= tsum > SW'(PeriodQ14);
      side6_q.t1     <= t1s[TW-1:0];
      side6_q.t2     <= t2s[TW-1:0];
    end
  end

  // overmodulation divider
  logic          vd_o;
  logic [QW-1:0] q1, q2;
  isp_side_t     sided;

  isp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .sum_i   (sum6_q),
    .side_i  (side6_q),
    .valid_o (vd_o),
    .quo1_o  (q1),
    .quo2_o  (q2),
    .side_o  (sided)
  );

  // stage 7: zero vector split and phase on-times
  logic [QW-1:0]  t1f, t2f, t0, full, mid;
  logic [PhW-1:0] ta, tb, tc;
  logic           v7_q;
  logic [PhW-1:0] ta7_q, tb7_q, tc7_q;
  logic [2:0]     sec7_q;

  always_comb begin
    t1f  = sided.over ? q1 : QW'(sided.t1);
    t2f  = sided.over ? q2 : QW'(sided.t2);
    t0   = (PeriodQ14 - t1f - t2f) >> 1;
    mid  = t2f + t0;
    full = t1f + mid;
    case (sided.sector)
      Sec1:    begin ta = full; tb = mid;  tc = t0;   end
      Sec2:    begin ta = mid;  tb = full; tc = t0;   end
      Sec3:    begin ta = t0;   tb = full; tc = mid;  end
      Sec4:    begin ta = t0;   tb = mid;  tc = full; end
      Sec5:    begin ta = mid;  tb = t0;   tc = full; end
      Sec6:    begin ta = full; tb = t0;   tc = mid;  end
      default: begin ta = HalfPeriodQ14; tb = HalfPeriodQ14; tc = HalfPeriodQ14; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ta7_q  <= ta;
      tb7_q  <= tb;
      tc7_q  <= tc;
      sec7_q <= sided.sector;
    end
  end

  // stage 8: gain products
  logic        v8_q;
  logic [30:0] ga8_q, gb8_q, gc8_q;
  logic [2:0]  sec8_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ga8_q  <= 31'(gain_q) * 31'(ta7_q);
      gb8_q  <= 31'(gain_q) * 31'(tb7_q);
      gc8_q  <= 31'(gain_q) * 31'(tc7_q);
      sec8_q <= sec7_q;
    end
  end

  // stage 9: compare values with saturation at zero
  function automatic logic [15:0] to_cmp(logic [30:0] prod, logic [15:0] top);
    logic [31:0] r;
    logic [16:0] dec;
    r = 32'(prod) + 32'd16383;
    dec = r[30:14];
    return (dec >= 17'(top)) ? 16'd0 : 16'(17'(top) - dec);
  endfunction

  logic        out_valid_q;
  logic [15:0] cmpa_q, cmpb_q, cmpc_q;
  logic [2:0]  seco_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmpa_q <= to_cmp(ga8_q, top_q);
      cmpb_q <= to_cmp(gb8_q, top_q);
      cmpc_q <= to_cmp(gc8_q, top_q);
      seco_q <= sec8_q;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
      v8_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_ch.valid;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      v6_q        <= v5_q;
      v7_q        <= vd_o;
      v8_q        <= v7_q;
      out_valid_q <= v8_q;
    end
  end

  // pipeline advances when the output register is free or being taken
  assign en          = !out_valid_q || out_ch.ready;
  assign in_ch.ready = en;

  assign out_ch.valid       = out_valid_q;
  assign out_ch.cmp_phase_a = cmpa_q;
  assign out_ch.cmp_phase_b = cmpb_q;
  assign out_ch.cmp_phase_c = cmpc_q;
  assign out_ch.sector_num  = seco_q;

  // null vector gives equal duties on all phases
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && seco_q == SecNull |-> cmpa_q == cmpb_q && cmpb_q == cmpc_q)
    else $error("null vector with unequal phase compares");

  // sector number never exceeds six
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> seco_q <= Sec6)
    else $error("sector number out of range");

  // scaled active times fit in one period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vd_o && sided.over && sided.sector != SecNull |->
      (16'(q1) + 16'(q2)) <= 16'(PeriodQ14))
    else $error("overmodulation scaling exceeds one period");

  // a stalled result blocks new input transactions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while output stalled");

endmodule
